// ===== rtl/ip_forward_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the forwarding lookup block
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef IP_FORWARD_LOOKUP_DEFINES_SVH
`define IP_FORWARD_LOOKUP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifl assertion failed");

`endif

// ===== rtl/ifl_pkg.sv =====
// ----------------------------------------------------------------------------
// ifl_pkg
// Types and codes shared by the forwarding lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifl_pkg;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;

    localparam t_op OP_LOAD_ROUTE = 2'd0;
    localparam t_op OP_LOAD_NBR   = 2'd1;
    localparam t_op OP_LOAD_PMAC  = 2'd2;
    localparam t_op OP_LOOKUP     = 2'd3;

    localparam t_status ST_LOADED   = 3'd0;
    localparam t_status ST_GATEWAY  = 3'd1;
    localparam t_status ST_DIRECT   = 3'd2;
    localparam t_status ST_NO_ROUTE = 3'd3;
    localparam t_status ST_NBR_MISS = 3'd4;

    typedef struct packed {
        logic [31:0] net;
        logic [31:0] mask;
        logic        gw;
        logic [47:0] mac;
        logic [1:0]  port;
    } t_route_entry;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_nbr_entry;

endpackage

`default_nettype wire

// ===== rtl/ifl_if.sv =====
// ----------------------------------------------------------------------------
// ifl_if
// Request and response channels of the forwarding lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ifl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] ip_addr;
    logic [31:0] net_mask;
    logic        via_gateway;
    logic [47:0] mac_addr;
    logic [1:0]  port;

    modport source (output valid, op, slot, ip_addr, net_mask, via_gateway, mac_addr, port,
                    input ready);
    modport sink (input valid, op, slot, ip_addr, net_mask, via_gateway, mac_addr, port,
                  output ready);
endinterface

interface ifl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [1:0]  egress_port;
    logic [3:0]  route_index;

    modport source (output valid, status, dst_mac, src_mac, egress_port, route_index,
                    input ready);
    modport sink (input valid, status, dst_mac, src_mac, egress_port, route_index,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ifl_match.sv =====
// ----------------------------------------------------------------------------
// ifl_match
// Shared masked equality compare used by both table walks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifl_match (
    input  logic [31:0] i_key,
    input  logic [31:0] i_mask,
    input  logic [31:0] i_pattern,
    output logic        o_hit
);

    assign o_hit = ((i_key & i_mask) == i_pattern);

endmodule

`default_nettype wire

// ===== rtl/ip_forward_lookup.sv =====
// A load item moves from idle to S_FIN; its result is registered once the output can take it.
// A lookup walks the route table one slot a cycle through the shared compare unit;
// on a hit it reads the egress port MAC and, for a direct route, walks the neighbor
// table the same way. One item at a time.
// Synchronous active-low reset clears the sequencer, the valid bits and the output valid flag.
// ----------------------------------------------------------------------------
// ip_forward_lookup
// IPv4 forwarding decision over a route table, a neighbor table and port MACs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ip_forward_lookup
    import ifl_pkg::*;
#(
    parameter int ROUTE_SLOTS = 16,
    parameter int NBR_SLOTS   = 16,
    parameter int PORTS       = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifl_in_if.sink    i_req,
    ifl_out_if.source o_rsp
);

    localparam int RW = $clog2(ROUTE_SLOTS);
    localparam int NW = $clog2(NBR_SLOTS);
    localparam int PW = $clog2(PORTS);
    localparam int CW = (RW > NW) ? RW : NW;

    localparam logic [CW-1:0] RLAST = CW'(ROUTE_SLOTS - 1);
    localparam logic [CW-1:0] NLAST = CW'(NBR_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUTE = 3'd1;
    localparam logic [2:0] S_PORT  = 3'd2;
    localparam logic [2:0] S_PCAP  = 3'd3;
    localparam logic [2:0] S_NBR   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    t_route_entry m_route [ROUTE_SLOTS];
    t_nbr_entry   m_nbr   [NBR_SLOTS];
    logic [47:0]  m_pmac  [PORTS];

    t_route_entry r_rt_rd;
    t_nbr_entry   r_nb_rd;
    logic [47:0]  r_pm_rd;

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_issue, n_issue;
    logic                   r_chk, n_chk;
    logic                   r_chk_v, n_chk_v;
    logic [CW-1:0]          r_chk_idx, n_chk_idx;
    logic [ROUTE_SLOTS-1:0] r_rvalid, n_rvalid;
    logic [NBR_SLOTS-1:0]   r_nvalid, n_nvalid;
    logic                   r_out_valid, n_out_valid;

    logic [31:0]  r_dst_ip;
    t_route_entry r_hit;
    logic [RW-1:0] r_hit_idx;
    t_status      r_res_status;
    logic [47:0]  r_res_dst;
    logic [47:0]  r_res_src;
    logic [1:0]   r_res_port;
    logic [3:0]   r_res_idx;
    t_status      r_o_status;
    logic [47:0]  r_o_dst;
    logic [47:0]  r_o_src;
    logic [1:0]   r_o_port;
    logic [3:0]   r_o_idx;

    logic          w_acc;
    logic          w_rslot_ok;
    logic          w_nslot_ok;
    logic          w_pslot_ok;
    logic          w_port_ok;
    logic [RW-1:0] w_rwaddr;
    logic [NW-1:0] w_nwaddr;
    logic [PW-1:0] w_pwaddr;
    logic [RW-1:0] w_raddr;
    logic [NW-1:0] w_naddr;
    logic [PW-1:0] w_paddr;
    logic [31:0]   w_mask;
    logic [31:0]   w_pattern;
    logic          w_match;
    logic          w_hit;
    logic          w_last;
    logic          w_fin_go;

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;

    assign w_rslot_ok = (32'(i_req.slot) < 32'(ROUTE_SLOTS));
    assign w_nslot_ok = (32'(i_req.slot) < 32'(NBR_SLOTS));
    assign w_pslot_ok = (32'(i_req.slot) < 32'(PORTS));
    assign w_port_ok  = (32'(r_hit.port) < 32'(PORTS));
    assign w_rwaddr   = RW'(i_req.slot);
    assign w_nwaddr   = NW'(i_req.slot);
    assign w_pwaddr   = PW'(i_req.slot);
    assign w_raddr    = r_cnt[RW-1:0];
    assign w_naddr    = r_cnt[NW-1:0];
    assign w_paddr    = PW'(r_hit.port);

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req.op == OP_LOAD_ROUTE) && w_rslot_ok) begin
            m_route[w_rwaddr] <= '{net: i_req.ip_addr, mask: i_req.net_mask,
                                   gw: i_req.via_gateway, mac: i_req.mac_addr,
                                   port: i_req.port};
        end
        if (w_acc && (i_req.op == OP_LOAD_NBR) && w_nslot_ok) begin
            m_nbr[w_nwaddr] <= '{ip: i_req.ip_addr, mac: i_req.mac_addr};
        end
        if (w_acc && (i_req.op == OP_LOAD_PMAC) && w_pslot_ok) begin
            m_pmac[w_pwaddr] <= i_req.mac_addr;
        end
        r_rt_rd <= m_route[w_raddr];
        r_nb_rd <= m_nbr[w_naddr];
        r_pm_rd <= m_pmac[w_paddr];
    end

    assign w_mask    = (r_state == S_ROUTE) ? r_rt_rd.mask : 32'hFFFF_FFFF;
    assign w_pattern = (r_state == S_ROUTE) ? r_rt_rd.net : r_nb_rd.ip;

    ifl_match u_match (
        .i_key     (r_dst_ip),
        .i_mask    (w_mask),
        .i_pattern (w_pattern),
        .o_hit     (w_match)
    );

    assign w_hit    = r_chk && r_chk_v && w_match;
    assign w_last   = r_chk && (r_chk_idx == ((r_state == S_ROUTE) ? RLAST : NLAST));
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_chk_v     = r_chk_v;
        n_chk_idx   = r_chk_idx;
        n_rvalid    = r_rvalid;
        n_nvalid    = r_nvalid;
        n_out_valid = r_out_valid;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.op)
                        OP_LOAD_ROUTE: begin
                            if (w_rslot_ok) begin
                                n_rvalid[w_rwaddr] = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        OP_LOAD_NBR: begin
                            if (w_nslot_ok) begin
                                n_nvalid[w_nwaddr] = 1'b1;
                            end
                            n_state = S_FIN;
                        end
                        OP_LOOKUP: begin
                            n_cnt   = '0;
                            n_issue = 1'b1;
                            n_state = S_ROUTE;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_ROUTE, S_NBR: begin
                if (r_issue) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt;
                    n_chk_v   = (r_state == S_ROUTE) ? r_rvalid[w_raddr] : r_nvalid[w_naddr];
                    if (r_cnt == ((r_state == S_ROUTE) ? RLAST : NLAST)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                if (w_hit) begin
                    n_chk   = 1'b0;
                    n_issue = 1'b0;
                    n_state = (r_state == S_ROUTE) ? S_PORT : S_FIN;
                end else if (w_last) begin
                    n_chk   = 1'b0;
                    n_issue = 1'b0;
                    n_state = S_FIN;
                end
            end
            S_PORT: begin
                n_state = S_PCAP;
            end
            S_PCAP: begin
                if (r_hit.gw) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt   = '0;
                    n_issue = 1'b1;
                    n_state = S_NBR;
                end
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_chk_v     <= 1'b0;
            r_chk_idx   <= '0;
            r_rvalid    <= '0;
            r_nvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_chk_v     <= n_chk_v;
            r_chk_idx   <= n_chk_idx;
            r_rvalid    <= n_rvalid;
            r_nvalid    <= n_nvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dst_ip     <= i_req.ip_addr;
                r_res_status <= ST_LOADED;
                r_res_dst    <= '0;
                r_res_src    <= '0;
                r_res_port   <= '0;
                r_res_idx    <= '0;
            end
            S_ROUTE: begin
                if (w_hit) begin
                    r_hit     <= r_rt_rd;
                    r_hit_idx <= r_chk_idx[RW-1:0];
                end else if (w_last) begin
                    r_res_status <= ST_NO_ROUTE;
                end
            end
            S_PCAP: begin
                r_res_src    <= w_port_ok ? r_pm_rd : 48'd0;
                r_res_port   <= r_hit.port;
                r_res_idx    <= 4'(r_hit_idx);
                r_res_status <= r_hit.gw ? ST_GATEWAY : ST_NBR_MISS;
                r_res_dst    <= r_hit.gw ? r_hit.mac : 48'd0;
            end
            S_NBR: begin
                if (w_hit) begin
                    r_res_status <= ST_DIRECT;
                    r_res_dst    <= r_nb_rd.mac;
                end
            end
            default: begin
            end
        endcase
        if (w_fin_go) begin
            r_o_status <= r_res_status;
            r_o_dst    <= r_res_dst;
            r_o_src    <= r_res_src;
            r_o_port   <= r_res_port;
            r_o_idx    <= r_res_idx;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.dst_mac     = r_o_dst;
    assign o_rsp.src_mac     = r_o_src;
    assign o_rsp.egress_port = r_o_port;
    assign o_rsp.route_index = r_o_idx;

endmodule

`default_nettype wire

// ===== rtl/ifl_checker.sv =====
// ----------------------------------------------------------------------------
// ifl_checker
// Port-level checks on the result channel of the forwarding lookup block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ip_forward_lookup_defines.svh"

module ifl_checker
    import ifl_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_status,
    input wire logic [47:0] i_dst_mac,
    input wire logic [47:0] i_src_mac,
    input wire logic [1:0]  i_egress_port,
    input wire logic [3:0]  i_route_index
);

    `IFL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `IFL_ASSERT_SAME(a_status_range, i_clk, i_rst_n, i_out_valid, i_status <= ST_NBR_MISS)

    `IFL_ASSERT_SAME(a_zero_fields, i_clk, i_rst_n, i_out_valid && (i_status == ST_LOADED || i_status == ST_NO_ROUTE), i_dst_mac == 48'd0 && i_src_mac == 48'd0 && i_egress_port == 2'd0 && i_route_index == 4'd0)

    `IFL_ASSERT_SAME(a_miss_dst, i_clk, i_rst_n, i_out_valid && i_status == ST_NBR_MISS, i_dst_mac == 48'd0)

endmodule

bind ip_forward_lookup ifl_checker u_ifl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_dst_mac     (o_rsp.dst_mac),
    .i_src_mac     (o_rsp.src_mac),
    .i_egress_port (o_rsp.egress_port),
    .i_route_index (o_rsp.route_index)
);

`default_nettype wire

// ===== verif/tb_ip_forward_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_forward_lookup
// Self-checking testbench for the IPv4 forwarding decision block. Route,
// neighbor and port MAC loads are mirrored in a scoreboard that predicts
// each response. A short directed sequence covers field extremes, route
// priority, shadowed and rewritten slots, port slots outside the table, and
// every status. Random traffic biased toward hitting loaded routes and
// neighbors follows, under three sender and receiver stall patterns.
// ----------------------------------------------------------------------------

module tb_ip_forward_lookup;
    import ifl_pkg::*;

    localparam int ROUTE_SLOTS  = 16;
    localparam int NBR_SLOTS    = 16;
    localparam int PORTS        = 4;
    localparam int PHASE_ITEMS  = 430;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        t_op         op;
        logic [3:0]  slot;
        logic [31:0] ip_addr;
        logic [31:0] net_mask;
        logic        via_gateway;
        logic [47:0] mac_addr;
        logic [1:0]  port;
    } req_item_t;

    typedef struct {
        t_status     status;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [1:0]  egress_port;
        logic [3:0]  route_index;
    } decision_t;

    class fwd_decision_board;
        t_route_entry route_tab[ROUTE_SLOTS];
        bit           route_live[ROUTE_SLOTS];
        t_nbr_entry   nbr_tab[NBR_SLOTS];
        bit           nbr_live[NBR_SLOTS];
        logic [47:0]  port_src_mac[PORTS];
        decision_t    awaited_decisions[$];
        int           errors;

        function void note_request(req_item_t r);
            decision_t d;
            int hit;
            int nbr_hit;
            int k;
            d.status      = ST_LOADED;
            d.dst_mac     = '0;
            d.src_mac     = '0;
            d.egress_port = '0;
            d.route_index = '0;
            case (r.op)
                OP_LOAD_ROUTE: begin
                    route_tab[r.slot].net  = r.ip_addr;
                    route_tab[r.slot].mask = r.net_mask;
                    route_tab[r.slot].gw   = r.via_gateway;
                    route_tab[r.slot].mac  = r.mac_addr;
                    route_tab[r.slot].port = r.port;
                    route_live[r.slot]     = 1'b1;
                end
                OP_LOAD_NBR: begin
                    nbr_tab[r.slot].ip  = r.ip_addr;
                    nbr_tab[r.slot].mac = r.mac_addr;
                    nbr_live[r.slot]    = 1'b1;
                end
                OP_LOAD_PMAC: begin
                    if (r.slot < PORTS) begin
                        port_src_mac[r.slot[1:0]] = r.mac_addr;
                    end
                end
                default: begin
                    hit = -1;
                    for (k = 0; k < ROUTE_SLOTS; k++) begin
                        if (hit < 0 && route_live[k] &&
                            (r.ip_addr & route_tab[k].mask) == route_tab[k].net) begin
                            hit = k;
                        end
                    end
                    if (hit < 0) begin
                        d.status = ST_NO_ROUTE;
                    end else begin
                        d.src_mac     = port_src_mac[route_tab[hit].port];
                        d.egress_port = route_tab[hit].port;
                        d.route_index = hit[3:0];
                        if (route_tab[hit].gw) begin
                            d.status  = ST_GATEWAY;
                            d.dst_mac = route_tab[hit].mac;
                        end else begin
                            nbr_hit = -1;
                            for (k = 0; k < NBR_SLOTS; k++) begin
                                if (nbr_hit < 0 && nbr_live[k] && nbr_tab[k].ip == r.ip_addr) begin
                                    nbr_hit = k;
                                end
                            end
                            if (nbr_hit < 0) begin
                                d.status = ST_NBR_MISS;
                            end else begin
                                d.status  = ST_DIRECT;
                                d.dst_mac = nbr_tab[nbr_hit].mac;
                            end
                        end
                    end
                end
            endcase
            awaited_decisions.push_back(d);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_response(decision_t got);
            decision_t want;
            if (awaited_decisions.size() == 0) begin
                $error("response with no request outstanding, status %0d", got.status);
                errors++;
                return;
            end
            want = awaited_decisions.pop_front();
            compare_field("status", 48'(want.status), 48'(got.status));
            compare_field("dst_mac", want.dst_mac, got.dst_mac);
            compare_field("src_mac", want.src_mac, got.src_mac);
            compare_field("egress_port", 48'(want.egress_port), 48'(got.egress_port));
            compare_field("route_index", 48'(want.route_index), 48'(got.route_index));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   cycle_count;

    logic [31:0] gen_net[ROUTE_SLOTS];
    logic [31:0] gen_mask[ROUTE_SLOTS];
    bit          gen_live[ROUTE_SLOTS];
    logic [31:0] nbr_addr[NBR_SLOTS];
    bit          nbr_seen[NBR_SLOTS];

    fwd_decision_board board;

    ifl_in_if  req_ch ();
    ifl_out_if rsp_ch ();

    ip_forward_lookup DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[47:0];
    endfunction

    function automatic req_item_t rand_item();
        req_item_t r;
        r.op          = t_op'($urandom_range(0, 3));
        r.slot        = 4'($urandom_range(0, 15));
        r.ip_addr     = $urandom();
        r.net_mask    = $urandom();
        r.via_gateway = 1'($urandom_range(0, 1));
        r.mac_addr    = rand_mac();
        r.port        = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic logic [31:0] host_of(int k);
        return gen_net[k] | ($urandom() & ~gen_mask[k]);
    endfunction

    task automatic send_item(req_item_t r);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= r.op;
        req_ch.slot        <= r.slot;
        req_ch.ip_addr     <= r.ip_addr;
        req_ch.net_mask    <= r.net_mask;
        req_ch.via_gateway <= r.via_gateway;
        req_ch.mac_addr    <= r.mac_addr;
        req_ch.port        <= r.port;
        do @(posedge i_clk); while (!req_ch.ready);
        board.note_request(r);
    endtask

    task automatic load_route(int slot, logic [31:0] net, logic [31:0] mask, logic gw,
                              logic [47:0] mac, logic [1:0] port);
        req_item_t r;
        r             = rand_item();
        r.op          = OP_LOAD_ROUTE;
        r.slot        = 4'(slot);
        r.ip_addr     = net;
        r.net_mask    = mask;
        r.via_gateway = gw;
        r.mac_addr    = mac;
        r.port        = port;
        gen_net[slot]  = net;
        gen_mask[slot] = mask;
        gen_live[slot] = 1'b1;
        send_item(r);
    endtask

    task automatic load_nbr(int slot, logic [31:0] ip, logic [47:0] mac);
        req_item_t r;
        r          = rand_item();
        r.op       = OP_LOAD_NBR;
        r.slot     = 4'(slot);
        r.ip_addr  = ip;
        r.mac_addr = mac;
        nbr_addr[slot] = ip;
        nbr_seen[slot] = 1'b1;
        send_item(r);
    endtask

    task automatic load_port_mac(int slot, logic [47:0] mac);
        req_item_t r;
        r          = rand_item();
        r.op       = OP_LOAD_PMAC;
        r.slot     = 4'(slot);
        r.mac_addr = mac;
        send_item(r);
    endtask

    task automatic lookup(logic [31:0] ip);
        req_item_t r;
        r         = rand_item();
        r.op      = OP_LOOKUP;
        r.ip_addr = ip;
        send_item(r);
    endtask

    task automatic random_item();
        int sel;
        int k;
        int plen;
        logic [31:0] mask;
        logic [31:0] ip;
        sel = $urandom_range(0, 99);
        k   = $urandom_range(0, ROUTE_SLOTS - 1);
        if (sel < 25) begin
            if ($urandom_range(0, 9) == 0) begin
                mask = $urandom();
            end else begin
                plen = ($urandom_range(0, 99) < 3) ? 0 : $urandom_range(8, 32);
                mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
            end
            ip = $urandom();
            if ($urandom_range(0, 9) != 0) ip = ip & mask;
            load_route(k, ip, mask, 1'($urandom_range(0, 1)), rand_mac(),
                       2'($urandom_range(0, 3)));
        end else if (sel < 45) begin
            ip = (gen_live[k] && $urandom_range(0, 9) < 7) ? host_of(k) : $urandom();
            load_nbr($urandom_range(0, NBR_SLOTS - 1), ip, rand_mac());
        end else if (sel < 50) begin
            load_port_mac($urandom_range(0, 15), rand_mac());
        end else begin
            sel = $urandom_range(0, 99);
            ip  = $urandom();
            if (sel < 40 && gen_live[k]) begin
                ip = host_of(k);
            end else if (sel < 65 && nbr_seen[k]) begin
                ip = nbr_addr[k];
            end else if (sel < 75 && gen_live[k]) begin
                ip = gen_net[k];
            end
            lookup(ip);
        end
    endtask

    initial begin
        decision_t got;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got.status      = rsp_ch.status;
                got.dst_mac     = rsp_ch.dst_mac;
                got.src_mac     = rsp_ch.src_mac;
                got.egress_port = rsp_ch.egress_port;
                got.route_index = rsp_ch.route_index;
                board.check_response(got);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial begin
        board        = new;
        src_idle_pct = 32;
        snk_idle_pct = 88;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_LOAD_ROUTE;
        req_ch.slot        = '0;
        req_ch.ip_addr     = '0;
        req_ch.net_mask    = '0;
        req_ch.via_gateway = 1'b0;
        req_ch.mac_addr    = '0;
        req_ch.port        = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty route table first, then port MACs including slots outside the table.
        lookup(32'h0A00_0001);
        load_port_mac(0, 48'h0);
        load_port_mac(1, 48'hFFFF_FFFF_FFFF);
        load_port_mac(2, 48'h0200_0000_0002);
        load_port_mac(3, 48'hA5A5_5A5A_A5A5);
        load_port_mac(15, 48'h1111_2222_3333);
        load_port_mac(4, 48'h4444_5555_6666);

        // Slot 1 is shadowed by the wider route in slot 0; slot 15 is the default route.
        load_route(0, 32'h0A00_0000, 32'hFF00_0000, 1'b1, 48'hAAAA_BBBB_CCCC, 2'd1);
        load_route(1, 32'h0A01_0000, 32'hFFFF_0000, 1'b0, 48'h0, 2'd2);
        load_route(2, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b0, 48'h0, 2'd3);
        load_route(15, 32'h0, 32'h0, 1'b1, 48'hFFFF_FFFF_FFFF, 2'd0);
        load_route(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 48'h0, 2'd0);
        load_nbr(0, 32'hC0A8_0107, 48'h0011_2233_4455);
        load_nbr(5, 32'hC0A8_0107, 48'h6677_8899_AABB);
        load_nbr(15, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        lookup(32'h0A01_0203);
        lookup(32'hC0A8_0107);
        lookup(32'hC0A8_0108);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0);

        // Rewritten slots take effect on the next lookup.
        load_nbr(0, 32'hC0A8_0108, 48'hCAFE_0000_0001);
        lookup(32'hC0A8_0107);
        load_route(0, 32'h0A01_0000, 32'hFFFF_0000, 1'b0, 48'h0, 2'd2);
        lookup(32'h0A01_0203);

        repeat (PHASE_ITEMS) random_item();
        src_idle_pct = 88;
        snk_idle_pct = 32;
        repeat (PHASE_ITEMS) random_item();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (PHASE_ITEMS) random_item();

        req_ch.valid <= 1'b0;
        while (board.awaited_decisions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
